### rtl/qsss_pkg.sv
// qsss_pkg: constants and shared types for the quad sprite step setup block
// no dependencies; used by quad_sprite_step_setup_top

package qsss_pkg;

   // fixed mapping scale, as a left shift of the corner differences
   localparam int unsigned SCALE_SHIFT = 20;
   // number of low bits of the size fields that take part
   localparam int unsigned SIZE_SHIFT_BITS = 4;

   localparam int unsigned COORD_W = 32;
   localparam int unsigned SIZE_W  = 4;
   // shift amounts cover the sum of two size fields and the scale offsets
   localparam int unsigned SHAMT_W = 6;

   localparam logic [SIZE_W-1:0] SIZE_MASK = SIZE_W'((1 << SIZE_SHIFT_BITS) - 1);

   typedef enum logic [0:0] {
      FUNC_HORIZONTAL  = 1'b0,
      FUNC_PERSPECTIVE = 1'b1
   } func_type;

   typedef logic [COORD_W-1:0] coord_type;

   // one captured input item
   typedef struct packed {
      func_type             func;
      coord_type            tl_x;
      coord_type            tl_y;
      coord_type            tr_x;
      coord_type            tr_y;
      coord_type            bl_x;
      coord_type            bl_y;
      coord_type            br_x;
      coord_type            br_y;
      logic [SIZE_W-1:0]    width_log2;
      logic [SIZE_W-1:0]    height_log2;
   } item_type;

   // one result item
   typedef struct packed {
      func_type  func;
      coord_type x_pos;
      coord_type y_pos;
      coord_type hdx;
      coord_type hdy;
      coord_type vdx;
      coord_type vdy;
      coord_type hddx;
      coord_type hddy;
   } result_type;

endpackage

### rtl/quad_sprite_step_setup_top.sv
// quad sprite step setup: corner points and sprite size to start position and step deltas
// depends on qsss_pkg (constants, item and result types)

// Takes the four corners of a screen quad and the log2 sprite width and height and
// returns the start position, the first-order steps hdx, hdy, vdx, vdy and the
// second-order steps hddx, hddy, all wrapping to 32 bits with arithmetic right
// shifts. func selects horizontal-only mapping (hdy and hddy forced to zero) or full
// perspective mapping. One item is taken every clock cycle while the result channel is
// not stalled. An item is captured in the input register when it is transferred in and
// moves on to the result register, from which its result is presented; the subtract
// and barrel-shift logic lies between those two registers. A stalled result holds the
// result register, and the input register holds once it is also full; nothing is kept
// between items.

module quad_sprite_step_setup_top (
   input  logic                  clock,
   input  logic                  reset,
   // input channel
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_func,
   input  logic signed [31:0]    req_tl_x,
   input  logic signed [31:0]    req_tl_y,
   input  logic signed [31:0]    req_tr_x,
   input  logic signed [31:0]    req_tr_y,
   input  logic signed [31:0]    req_bl_x,
   input  logic signed [31:0]    req_bl_y,
   input  logic signed [31:0]    req_br_x,
   input  logic signed [31:0]    req_br_y,
   input  logic        [3:0]     req_width_log2,
   input  logic        [3:0]     req_height_log2,
   // result channel
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic signed [31:0]    rsp_x_pos,
   output logic signed [31:0]    rsp_y_pos,
   output logic signed [31:0]    rsp_hdx,
   output logic signed [31:0]    rsp_hdy,
   output logic signed [31:0]    rsp_vdx,
   output logic signed [31:0]    rsp_vdy,
   output logic signed [31:0]    rsp_hddx,
   output logic signed [31:0]    rsp_hddy
);

   localparam logic [qsss_pkg::SHAMT_W-1:0] SCALE_AMT =
      qsss_pkg::SHAMT_W'(qsss_pkg::SCALE_SHIFT);

   // arithmetic right shift, sign fill for large amounts
   function automatic qsss_pkg::coord_type sar32(input qsss_pkg::coord_type v,
                                                 input logic [qsss_pkg::SHAMT_W-1:0] s);
      sar32 = qsss_pkg::coord_type'($signed(v) >>> s);
   endfunction

   // perspective scaling against the fixed mapping scale
   function automatic qsss_pkg::coord_type scale_by(input qsss_pkg::coord_type v,
                                                    input logic [qsss_pkg::SHAMT_W-1:0] n);
      if (n >= SCALE_AMT) begin
         scale_by = sar32(v, n - SCALE_AMT);
      end else begin
         scale_by = v << (SCALE_AMT - n);
      end
   endfunction

   qsss_pkg::item_type   item_ff, item_in;
   logic                 item_valid_ff, item_valid_in;
   qsss_pkg::result_type result_ff, result_in;
   logic                 result_valid_ff, result_valid_in;

   logic                 out_advance;
   logic                 in_advance;

   // stage handshakes: the result register frees when empty or taken
   assign out_advance = !result_valid_ff || rsp_ready;
   assign in_advance  = !item_valid_ff || out_advance;
   assign req_ready   = in_advance;

   // input capture
   always_comb begin
      item_in.func        = qsss_pkg::func_type'(req_func);
      item_in.tl_x        = req_tl_x;
      item_in.tl_y        = req_tl_y;
      item_in.tr_x        = req_tr_x;
      item_in.tr_y        = req_tr_y;
      item_in.bl_x        = req_bl_x;
      item_in.bl_y        = req_bl_y;
      item_in.br_x        = req_br_x;
      item_in.br_y        = req_br_y;
      item_in.width_log2  = req_width_log2;
      item_in.height_log2 = req_height_log2;
      item_valid_in       = in_advance ? req_valid : item_valid_ff;
   end

   // step delta computation
   logic [qsss_pkg::SHAMT_W-1:0] w_amt, h_amt, wh_amt;
   qsss_pkg::coord_type          top_dx, top_dy, persp_dx, persp_dy, neg_top_dx, neg_top_dy;

   always_comb begin
      w_amt      = qsss_pkg::SHAMT_W'(item_ff.width_log2 & qsss_pkg::SIZE_MASK);
      h_amt      = qsss_pkg::SHAMT_W'(item_ff.height_log2 & qsss_pkg::SIZE_MASK);
      wh_amt     = w_amt + h_amt;
      top_dx     = item_ff.tl_x - item_ff.tr_x;
      top_dy     = item_ff.tl_y - item_ff.tr_y;
      neg_top_dx = item_ff.tr_x - item_ff.tl_x;
      neg_top_dy = item_ff.tr_y - item_ff.tl_y;
      persp_dx   = item_ff.br_x - item_ff.bl_x + top_dx;
      persp_dy   = item_ff.br_y - item_ff.bl_y + top_dy;

      result_in.func  = item_ff.func;
      result_in.x_pos = item_ff.tl_x;
      result_in.y_pos = item_ff.tl_y;
      result_in.vdx   = sar32(item_ff.bl_x - item_ff.tl_x, h_amt);
      result_in.vdy   = sar32(item_ff.bl_y - item_ff.tl_y, h_amt);

      case (item_ff.func)
         qsss_pkg::FUNC_PERSPECTIVE: begin
            result_in.hdx  = scale_by(neg_top_dx, w_amt);
            result_in.hdy  = scale_by(neg_top_dy, w_amt);
            result_in.hddx = scale_by(persp_dx, wh_amt);
            result_in.hddy = scale_by(persp_dy, wh_amt);
         end
         qsss_pkg::FUNC_HORIZONTAL: begin
            result_in.hdx  = sar32(neg_top_dx << qsss_pkg::SCALE_SHIFT, w_amt);
            result_in.hdy  = '0;
            result_in.hddx = sar32(persp_dx << qsss_pkg::SCALE_SHIFT, wh_amt);
            result_in.hddy = '0;
         end
         default: begin
            result_in.hdx  = '0;
            result_in.hdy  = '0;
            result_in.hddx = '0;
            result_in.hddy = '0;
         end
      endcase

      result_valid_in = out_advance ? item_valid_ff : result_valid_ff;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff   <= 1'b0;
         result_valid_ff <= 1'b0;
      end else begin
         item_valid_ff   <= item_valid_in;
         result_valid_ff <= result_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (in_advance) begin
         item_ff <= item_in;
      end
      if (out_advance) begin
         result_ff <= result_in;
      end
   end

   // result ports
   assign rsp_valid = result_valid_ff;
   assign rsp_x_pos = result_ff.x_pos;
   assign rsp_y_pos = result_ff.y_pos;
   assign rsp_hdx   = result_ff.hdx;
   assign rsp_hdy   = result_ff.hdy;
   assign rsp_vdx   = result_ff.vdx;
   assign rsp_vdy   = result_ff.vdy;
   assign rsp_hddx  = result_ff.hddx;
   assign rsp_hddy  = result_ff.hddy;

`ifndef SYNTHESIS
   // horizontal mode never carries a vertical component in the horizontal steps
   assert property (@(posedge clock) disable iff (reset)
      result_valid_ff && (result_ff.func == qsss_pkg::FUNC_HORIZONTAL)
         |-> (result_ff.hdy == '0) && (result_ff.hddy == '0))
      else $error("hdy or hddy nonzero in horizontal mode");

   // an item in the input register moves on to the result register
   assert property (@(posedge clock) disable iff (reset)
      item_valid_ff && out_advance |=> result_valid_ff)
      else $error("item lost between stages");

   // a stalled result holds the item behind it in place
   assert property (@(posedge clock) disable iff (reset)
      item_valid_ff && result_valid_ff && !rsp_ready |=> item_valid_ff && result_valid_ff)
      else $error("input stage dropped an item under stall");

   // an empty input register always takes a transfer
   assert property (@(posedge clock) disable iff (reset)
      !item_valid_ff |-> req_ready)
      else $error("input not ready with empty stage");
`endif

endmodule
